/* design/bresenham_line_colour_interp_core_defines.svh */
// Assertion macros shared by the line rasterizer RTL.
`ifndef BRESENHAM_LINE_COLOUR_INTERP_CORE_DEFINES_SVH
`define BRESENHAM_LINE_COLOUR_INTERP_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define BLCI_ASSERT_IMP(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define BLCI_ASSERT_NXT(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* design/blci_pkg.sv */
// Shared constants and the line descriptor type of the line rasterizer.
`default_nettype none

package blci_pkg;

    localparam int COORD_BITS_DEF   = 6;
    localparam int CHANNEL_BITS_DEF = 8;
    localparam int CHANNEL_BITS_MAX = 12;
    localparam int FRAC_BITS        = 8;
    localparam int NUM_CH           = 4;

    localparam int COORD_W  = 6;
    localparam int DEPTH_W  = 16;
    localparam int COLOUR_W = 32;

    // Signed 14.8 accumulator, wide enough for the largest channel.
    localparam int ACC_W = CHANNEL_BITS_MAX + FRAC_BITS + 2;

    localparam int FIFO_DEPTH = 2;

    // Input item layout.
    localparam int IN_SX_LSB    = 0;
    localparam int IN_SY_LSB    = 6;
    localparam int IN_EX_LSB    = 12;
    localparam int IN_EY_LSB    = 18;
    localparam int IN_DEPTH_LSB = 24;
    localparam int IN_C0_LSB    = 40;
    localparam int IN_C1_LSB    = 72;
    localparam int IN_DATA_W    = 104;

    // Output item layout.
    localparam int OUT_X_LSB      = 0;
    localparam int OUT_Y_LSB      = 6;
    localparam int OUT_DEPTH_LSB  = 12;
    localparam int OUT_COLOUR_LSB = 28;
    localparam int OUT_DATA_W     = 64;

    typedef logic [NUM_CH-1:0][ACC_W-1:0] chan_acc_t;

    // One classified line, handed from the setup side to the walker.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] n;
        logic [COORD_W-1:0] amin;
        logic               steep;
        logic               neg_maj;
        logic               neg_min;
        logic [DEPTH_W-1:0] depth;
        chan_acc_t          acc0;
        chan_acc_t          delta;
    } line_t;

endpackage

`default_nettype wire

/* design/blci_fifo.sv */
// Short descriptor queue between line setup and the pixel walker.
`default_nettype none
`include "bresenham_line_colour_interp_core_defines.svh"

module blci_fifo
    import blci_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  wire line_t push_line,
    output logic       pop_valid,
    input  wire logic  pop_ready,
    output line_t      pop_line
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    line_t            mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_ready && pop_valid;
    assign pop_line   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_line;
        end
    end

    `BLCI_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH))

endmodule

`default_nettype wire

/* design/blci_front.sv */
// Line setup: accept a line, classify its axes and divide the colour slopes.
`default_nettype none
`include "bresenham_line_colour_interp_core_defines.svh"

module blci_front
    import blci_pkg::*;
#(
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_DATA_W-1:0] s_tdata,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output line_t                     push_line
);

    localparam int QW     = CHANNEL_BITS + FRAC_BITS;
    localparam int CNT_W  = $clog2(QW + 1);
    localparam int CW_ALL = NUM_CH * CHANNEL_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    line_t            line_reg, line_next;

    logic [QW-1:0]         dvd_reg  [NUM_CH];
    logic [QW-1:0]         dvd_next [NUM_CH];
    logic [COORD_BITS-1:0] rem_reg  [NUM_CH];
    logic [COORD_BITS-1:0] rem_next [NUM_CH];
    logic [NUM_CH-1:0]     neg_reg, neg_next;

    logic                  accept, div_step;
    logic [COORD_BITS-1:0] sx, sy, ex, ey;
    logic [COORD_BITS:0]   dx, dy;
    logic [COORD_BITS-1:0] adx, ady, n_in, amin_in, n_cur;
    logic                  steep_in;
    logic [CW_ALL-1:0]     c0_ext, c1_ext;
    logic [NUM_CH-1:0]     neg_in;
    chan_acc_t             acc0_in;
    wire  [NUM_CH-1:0][ACC_W-1:0] delta_out;

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign div_step   = (state_reg == S_DIV);
    assign push_valid = (state_reg == S_PUSH);
    assign n_cur      = line_reg.n[COORD_BITS-1:0];

    // Axis classification; ties go to x.
    assign sx = s_tdata[IN_SX_LSB +: COORD_BITS];
    assign sy = s_tdata[IN_SY_LSB +: COORD_BITS];
    assign ex = s_tdata[IN_EX_LSB +: COORD_BITS];
    assign ey = s_tdata[IN_EY_LSB +: COORD_BITS];
    assign dx = {1'b0, ex} - {1'b0, sx};
    assign dy = {1'b0, ey} - {1'b0, sy};
    assign adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    assign ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    assign steep_in = (ady > adx);
    assign n_in     = steep_in ? ady : adx;
    assign amin_in  = steep_in ? adx : ady;

    assign c0_ext = CW_ALL'(s_tdata[IN_C0_LSB +: COLOUR_W]);
    assign c1_ext = CW_ALL'(s_tdata[IN_C1_LSB +: COLOUR_W]);

    // One restoring divider lane per channel: one quotient bit a cycle,
    // the quotient shifts into the dividend register from the bottom.
    for (genvar g = 0; g < NUM_CH; g++)
    begin : g_lane
        logic [CHANNEL_BITS-1:0] ch_a, ch_b, ch_mag;
        logic [CHANNEL_BITS:0]   ch_diff;
        logic [COORD_BITS:0]     rem_try;
        logic                    rem_ge;

        assign ch_a    = c0_ext[(NUM_CH-1-g)*CHANNEL_BITS +: CHANNEL_BITS];
        assign ch_b    = c1_ext[(NUM_CH-1-g)*CHANNEL_BITS +: CHANNEL_BITS];
        assign ch_diff = {1'b0, ch_b} - {1'b0, ch_a};
        assign ch_mag  = ch_diff[CHANNEL_BITS] ? CHANNEL_BITS'(-ch_diff)
                                               : ch_diff[CHANNEL_BITS-1:0];
        assign neg_in[g]  = ch_diff[CHANNEL_BITS];
        assign acc0_in[g] = ACC_W'({ch_a, {FRAC_BITS{1'b0}}});

        assign rem_try = {rem_reg[g], dvd_reg[g][QW-1]};
        assign rem_ge  = (rem_try >= {1'b0, n_cur});

        assign dvd_next[g] = accept   ? {ch_mag, {FRAC_BITS{1'b0}}} :
                             div_step ? {dvd_reg[g][QW-2:0], rem_ge} : dvd_reg[g];
        assign rem_next[g] = accept   ? '0 :
                             div_step ? (rem_ge ? COORD_BITS'(rem_try - {1'b0, n_cur})
                                                : rem_try[COORD_BITS-1:0])
                                      : rem_reg[g];

        // Division truncates toward zero: divide magnitudes, restore sign.
        assign delta_out[g] = neg_reg[g] ? {ACC_W{1'b0}} - ACC_W'(dvd_reg[g])
                                         : ACC_W'(dvd_reg[g]);
    end

    assign neg_next = accept ? neg_in : neg_reg;

    always_comb
    begin
        line_next = line_reg;
        if (accept)
        begin
            line_next.x       = COORD_W'(sx);
            line_next.y       = COORD_W'(sy);
            line_next.n       = COORD_W'(n_in);
            line_next.amin    = COORD_W'(amin_in);
            line_next.steep   = steep_in;
            line_next.neg_maj = steep_in ? dy[COORD_BITS] : dx[COORD_BITS];
            line_next.neg_min = steep_in ? dx[COORD_BITS] : dy[COORD_BITS];
            line_next.depth   = s_tdata[IN_DEPTH_LSB +: DEPTH_W];
            line_next.acc0    = acc0_in;
            line_next.delta   = '0;
        end
    end

    always_comb
    begin
        push_line       = line_reg;
        push_line.delta = delta_out;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                // Drop zero-length lines here; they produce no pixels.
                if (accept && (n_in != '0))
                begin
                    state_next = S_DIV;
                    cnt_next   = CNT_W'(QW);
                end
            end
            S_DIV:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg <= line_next;
        neg_reg  <= neg_next;
        for (int c = 0; c < NUM_CH; c++)
        begin
            dvd_reg[c] <= dvd_next[c];
            rem_reg[c] <= rem_next[c];
        end
    end

    `BLCI_ASSERT_IMP(a_push_nonzero, clk, rst_n, push_valid, push_line.n != '0)
    `BLCI_ASSERT_IMP(a_div_count, clk, rst_n, state_reg == S_DIV, cnt_reg != '0)

endmodule

`default_nettype wire

/* design/blci_back.sv */
// Pixel walker: step a classified line one pixel a cycle into the output register unless m_ stalls.
`default_nettype none
`include "bresenham_line_colour_interp_core_defines.svh"

module blci_back
    import blci_pkg::*;
#(
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pop_valid,
    output logic                       pop_ready,
    input  wire line_t                 pop_line,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tlast
);

    localparam int ERR_W  = COORD_BITS + 3;
    localparam int CW_ALL = NUM_CH * CHANNEL_BITS;

    logic                     busy_reg, busy_next;
    logic                     out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0]    x_reg, y_reg, n_reg, amin_reg, rem_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic                     steep_reg, neg_maj_reg, neg_min_reg;
    logic [DEPTH_W-1:0]       depth_reg;
    logic signed [ACC_W-1:0]  acc_reg   [NUM_CH];
    logic signed [ACC_W-1:0]  delta_reg [NUM_CH];

    logic [COORD_W-1:0]       out_x_reg, out_y_reg;
    logic [DEPTH_W-1:0]       out_depth_reg;
    logic [COLOUR_W-1:0]      out_colour_reg;
    logic                     out_last_reg;

    logic                     load, step, last;
    logic signed [ERR_W-1:0]  err_sum, err_adv;
    logic                     err_over;
    logic [COORD_BITS-1:0]    maj_cur, min_cur, maj_adv, min_adv;
    wire  [CW_ALL-1:0]        colour;

    assign pop_ready = !busy_reg;
    assign load      = pop_valid && !busy_reg;
    assign step      = busy_reg && (!out_valid_reg || m_tready);
    assign last      = (rem_reg == COORD_BITS'(1));

    // Integer form of the slope-above-one-half test.
    assign err_sum  = err_reg + $signed({2'b00, amin_reg, 1'b0});
    assign err_over = (err_sum > $signed({3'b000, n_reg}));
    assign err_adv  = err_over ? err_sum - $signed({2'b00, n_reg, 1'b0}) : err_sum;

    assign maj_cur = steep_reg ? y_reg : x_reg;
    assign min_cur = steep_reg ? x_reg : y_reg;
    assign maj_adv = neg_maj_reg ? maj_cur - COORD_BITS'(1) : maj_cur + COORD_BITS'(1);
    assign min_adv = !err_over   ? min_cur :
                     neg_min_reg ? min_cur - COORD_BITS'(1) : min_cur + COORD_BITS'(1);

    // Truncate each channel and clamp to its range.
    for (genvar g = 0; g < NUM_CH; g++)
    begin : g_chan
        logic [CHANNEL_BITS-1:0] chv;

        always_comb
        begin
            priority if (acc_reg[g][ACC_W-1])
            begin
                chv = '0;
            end
            else if (|acc_reg[g][ACC_W-2:FRAC_BITS+CHANNEL_BITS])
            begin
                chv = '1;
            end
            else
            begin
                chv = acc_reg[g][FRAC_BITS +: CHANNEL_BITS];
            end
        end

        assign colour[(NUM_CH-1-g)*CHANNEL_BITS +: CHANNEL_BITS] = chv;
    end

    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            busy_next = 1'b1;
        end
        if (step)
        begin
            out_valid_next = 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg       <= pop_line.x[COORD_BITS-1:0];
            y_reg       <= pop_line.y[COORD_BITS-1:0];
            n_reg       <= pop_line.n[COORD_BITS-1:0];
            rem_reg     <= pop_line.n[COORD_BITS-1:0];
            amin_reg    <= pop_line.amin[COORD_BITS-1:0];
            err_reg     <= '0;
            steep_reg   <= pop_line.steep;
            neg_maj_reg <= pop_line.neg_maj;
            neg_min_reg <= pop_line.neg_min;
            depth_reg   <= pop_line.depth;
            for (int c = 0; c < NUM_CH; c++)
            begin
                acc_reg[c]   <= $signed(pop_line.acc0[c]);
                delta_reg[c] <= $signed(pop_line.delta[c]);
            end
        end
        else if (step)
        begin
            out_x_reg      <= COORD_W'(x_reg);
            out_y_reg      <= COORD_W'(y_reg);
            out_depth_reg  <= depth_reg;
            out_colour_reg <= COLOUR_W'(colour);
            out_last_reg   <= last;
            rem_reg        <= rem_reg - COORD_BITS'(1);
            err_reg        <= err_adv;
            x_reg          <= steep_reg ? min_adv : maj_adv;
            y_reg          <= steep_reg ? maj_adv : min_adv;
            for (int c = 0; c < NUM_CH; c++)
            begin
                acc_reg[c] <= acc_reg[c] + delta_reg[c];
            end
        end
    end

    always_comb
    begin
        m_tdata = '0;
        m_tdata[OUT_X_LSB +: COORD_W]       = out_x_reg;
        m_tdata[OUT_Y_LSB +: COORD_W]       = out_y_reg;
        m_tdata[OUT_DEPTH_LSB +: DEPTH_W]   = out_depth_reg;
        m_tdata[OUT_COLOUR_LSB +: COLOUR_W] = out_colour_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;

    `BLCI_ASSERT_IMP(a_busy_has_pixels, clk, rst_n, busy_reg, rem_reg != '0)
    `BLCI_ASSERT_NXT(a_last_ends_line, clk, rst_n, step && last, !busy_reg)

endmodule

`default_nettype wire

/* design/bresenham_line_colour_interp_core.sv */
// Top level of the Bresenham line rasterizer with per-pixel colour interpolation.
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ------------------------------------------------
//  s_       in   s_tvalid/s_tready  s_tdata: line endpoints, depth, two RGBA colours
//  m_       out  m_tvalid/m_tready  m_tdata: pixel x, y, depth, colour; m_tlast
//
// Setup divides the colour slopes in the four restoring divider lanes, which produce one
// slope bit per cycle each; it takes no new line until the finished one is queued.
// The walker emits a line of n pixels, one pixel per cycle while m_ is not stalled.
// A two-entry descriptor queue lets setup of the next line overlap emission of the
// current one. Reset is asynchronous and clears control state only; no clearing pass
// is needed. A stall on m_ holds the output register; setup keeps running until the
// queue fills.
`default_nettype none

module bresenham_line_colour_interp_core
    import blci_pkg::*;
#(
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Line in.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], depth_in[39:24],
    // start_colour[71:40], end_colour[103:72]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,

    // Pixels out.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // pixel_x[5:0], pixel_y[11:6], pixel_depth[27:12], pixel_colour[59:28], zero pad
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // last_pixel
    output logic                       m_tlast
);

    logic  push_valid, push_ready;
    line_t push_line;
    logic  pop_valid, pop_ready;
    line_t pop_line;

    // Accept a line, classify major/minor axes, divide the colour slopes.
    blci_front #(
        .COORD_BITS   (COORD_BITS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_line  (push_line)
    );

    // Hold finished descriptors so setup and emission stall independently.
    blci_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_line  (push_line),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_line   (pop_line)
    );

    // Walk the line and emit one pixel per cycle through the output register unless m_ stalls.
    blci_back #(
        .COORD_BITS   (COORD_BITS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_line  (pop_line),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
